@@ sv/atids_pkg.sv @@
package atids_pkg;

  typedef enum logic [2:0] {
    ACT_APPEND,
    ACT_INSERT,
    ACT_DELETE,
    ACT_EDIT,
    ACT_READ,
    ACT_SEARCH
  } act_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_MISSING,
    ST_BADPOS
  } status_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         position;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         found_index;
    logic signed [31:0] read_value;
    logic [4:0]         count;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SHIFT_DN,
    S_SHIFT_UP,
    S_READ
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_COUNT,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_POS
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_APPEND,
    WR_POS,
    WR_DOWN,
    WR_UP
  } wr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic    load;
    idx_op_t idx_op;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    cnt_op_t cnt_op;
    logic    fnd_ld;
    logic    done;
    status_t res_status;
    logic    res_rd;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic full;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic hit;
    logic idx_ge_cnt;
    logic idx_gt_pos;
    logic pv;
  } stat_t;

endpackage

@@ sv/atids_dp.sv @@
module atids_dp #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  atids_pkg::in_t   in_data,
  input  atids_pkg::cmd_t  cmd,
  output atids_pkg::stat_t stat,
  output logic             out_valid,
  output atids_pkg::out_t  out_data
);
  import atids_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > 5) ? CW : 5;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [2:0]            act_r;
  logic [3:0]            pos_r;
  logic [DATA_WIDTH-1:0] word_r;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [3:0]            fnd_r;
  logic                  pv_r;
  logic [DATA_WIDTH-1:0] rd_q;
  logic [AW-1:0]         addr_q;
  logic                  res_vld_r;
  out_t                  res_r;

  logic [63:0]           wext;
  logic [63:0]           rext;
  logic [CW-1:0]         idx_m1;
  logic [EW-1:0]         pos_ext, cnt_ext, idx_ext, idx_m1_ext, cnt_nxt_ext;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [3:0]            fnd_val;

  assign wext        = {{32{in_data.value[31]}}, in_data.value};
  assign rext        = 64'(rd_q);
  assign idx_m1      = idx_r - 1'b1;
  assign pos_ext     = EW'(pos_r);
  assign cnt_ext     = EW'(cnt_r);
  assign idx_ext     = EW'(idx_r);
  assign idx_m1_ext  = EW'(idx_m1);
  assign cnt_nxt_ext = EW'(cnt_nxt);
  assign fnd_val     = cmd.fnd_ld ? idx_m1_ext[3:0] : fnd_r;

  always_comb begin
    case (cmd.rd_sel)
      RD_IDX:    rd_addr = idx_r[AW-1:0];
      RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
      default:   rd_addr = pos_ext[AW-1:0];
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_APPEND: begin
        wr_addr = cnt_r[AW-1:0];
        wr_data = word_r;
      end
      WR_POS: begin
        wr_addr = pos_ext[AW-1:0];
        wr_data = word_r;
      end
      WR_DOWN: begin
        wr_addr = addr_q - 1'b1;
        wr_data = rd_q;
      end
      default: begin
        wr_addr = addr_q + 1'b1;
        wr_data = rd_q;
      end
    endcase
  end

  always_comb begin
    case (cmd.idx_op)
      IDX_ZERO:  idx_nxt = '0;
      IDX_COUNT: idx_nxt = cnt_r;
      IDX_INC:   idx_nxt = idx_r + 1'b1;
      IDX_DEC:   idx_nxt = idx_m1;
      default:   idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC: cnt_nxt = cnt_r + 1'b1;
      CNT_DEC: cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_q   <= mem[rd_addr];
      addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_data.action;
      pos_r  <= in_data.position;
      word_r <= wext[DATA_WIDTH-1:0];
      fnd_r  <= '0;
    end else if (cmd.fnd_ld) begin
      fnd_r <= idx_m1_ext[3:0];
    end
    idx_r <= idx_nxt;
    if (cmd.done) begin
      res_r.status      <= cmd.res_status;
      res_r.found_index <= fnd_val;
      res_r.read_value  <= cmd.res_rd ? rext[31:0] : '0;
      res_r.count       <= cnt_nxt_ext[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      pv_r      <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      pv_r      <= cmd.rd_en;
      res_vld_r <= cmd.done;
    end
  end

  assign stat.act        = act_t'(act_r);
  assign stat.full       = (cnt_r == CW'(DEPTH));
  assign stat.pos_gt_cnt = (pos_ext > cnt_ext);
  assign stat.pos_ge_cnt = (pos_ext >= cnt_ext);
  assign stat.hit        = pv_r && (rd_q == word_r);
  assign stat.idx_ge_cnt = (idx_r >= cnt_r);
  assign stat.idx_gt_pos = (idx_ext > pos_ext);
  assign stat.pv         = pv_r;

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt_op == CNT_INC) |-> !stat.full)
    else $error("count increment on full table");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt_op == CNT_DEC) |-> (cnt_r != '0))
    else $error("count decrement on empty table");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r |=> !res_vld_r)
    else $error("result strobe longer than one cycle");
`endif

endmodule

@@ sv/atids_ctrl.sv @@
module atids_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  atids_pkg::stat_t stat,
  output atids_pkg::cmd_t  cmd,
  output logic             busy
);
  import atids_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_nxt = S_IDLE;
        case (stat.act)
          ACT_INSERT: begin
            if (!stat.full && !stat.pos_gt_cnt) state_nxt = S_SHIFT_UP;
          end
          ACT_DELETE, ACT_SEARCH: state_nxt = S_SCAN;
          ACT_READ: begin
            if (!stat.pos_ge_cnt) state_nxt = S_READ;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (stat.hit) begin
          state_nxt = (stat.act == ACT_DELETE) ? S_SHIFT_DN : S_IDLE;
        end else if (stat.idx_ge_cnt) begin
          state_nxt = S_IDLE;
        end
      end
      S_SHIFT_DN: begin
        if (stat.idx_ge_cnt && !stat.pv) state_nxt = S_IDLE;
      end
      S_SHIFT_UP: begin
        if (!stat.idx_gt_pos && !stat.pv) state_nxt = S_IDLE;
      end
      S_READ:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.idx_op     = IDX_HOLD;
    cmd.rd_sel     = RD_IDX;
    cmd.wr_sel     = WR_APPEND;
    cmd.cnt_op     = CNT_HOLD;
    cmd.res_status = ST_OK;
    busy           = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        cmd.load = start;
      end
      S_DISPATCH: begin
        case (stat.act)
          ACT_APPEND: begin
            cmd.done = 1'b1;
            if (stat.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = WR_APPEND;
              cmd.cnt_op = CNT_INC;
            end
          end
          ACT_INSERT: begin
            if (stat.full) begin
              cmd.done       = 1'b1;
              cmd.res_status = ST_FULL;
            end else if (stat.pos_gt_cnt) begin
              cmd.done       = 1'b1;
              cmd.res_status = ST_BADPOS;
            end else begin
              cmd.idx_op = IDX_COUNT;
            end
          end
          ACT_DELETE, ACT_SEARCH: begin
            cmd.idx_op = IDX_ZERO;
          end
          ACT_EDIT: begin
            cmd.done = 1'b1;
            if (stat.pos_ge_cnt) begin
              cmd.res_status = ST_BADPOS;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = WR_POS;
            end
          end
          ACT_READ: begin
            if (stat.pos_ge_cnt) begin
              cmd.done       = 1'b1;
              cmd.res_status = ST_BADPOS;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_POS;
            end
          end
          default: begin
            cmd.done = 1'b1;
          end
        endcase
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.fnd_ld = 1'b1;
          cmd.done   = (stat.act != ACT_DELETE);
        end else if (stat.idx_ge_cnt) begin
          cmd.done       = 1'b1;
          cmd.res_status = ST_MISSING;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
          cmd.idx_op = IDX_INC;
        end
      end
      S_SHIFT_DN: begin
        if (stat.pv) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_DOWN;
        end
        if (!stat.idx_ge_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
          cmd.idx_op = IDX_INC;
        end else if (!stat.pv) begin
          cmd.cnt_op = CNT_DEC;
          cmd.done   = 1'b1;
        end
      end
      S_SHIFT_UP: begin
        if (stat.pv) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_UP;
        end
        if (stat.idx_gt_pos) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_M1;
          cmd.idx_op = IDX_DEC;
        end else if (!stat.pv) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_POS;
          cmd.cnt_op = CNT_INC;
          cmd.done   = 1'b1;
        end
      end
      S_READ: begin
        cmd.done   = 1'b1;
        cmd.res_rd = 1'b1;
      end
      default: begin
        cmd.done = 1'b0;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_read_follows_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> $past(cmd.rd_en))
    else $error("read result without memory fetch");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.done && state_r == S_SHIFT_UP) |-> !stat.pv)
    else $error("insert completes with shift write pending");

  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done |=> (state_r == S_IDLE))
    else $error("controller not idle after completion");
`endif

endmodule

@@ sv/array_table_insert_delete_search.sv @@
// Append, edit and unused codes finish in dispatch; read fetches the entry at the
// position; search scans up from index 0; insert shifts the entries at and above the
// position up and writes there; delete scans, then shifts later entries down; a miss
// gives status missing. Busy drops in the strobe cycle, so one request at a time.
// The table memory (one write, one registered read per cycle) is walked one entry a cycle.
// Reset (rst_n low, synchronous) empties the table and idles the controller; results
// cannot be stalled by the receiver.
module array_table_insert_delete_search #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  atids_pkg::in_t  in_data,
  output logic            out_valid,
  output atids_pkg::out_t out_data
);
  import atids_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  atids_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  atids_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
